// File: hdl/ksv_pkg.sv
`default_nettype none
package ksv_pkg;

  // Table geometry
  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int KC_W     = 7;
  localparam int NK_W     = $clog2(MAX_KEYS + 1);
  localparam int N_W      = (KC_W > NK_W) ? KC_W : NK_W;

  // Arithmetic widths
  localparam int VAL_W    = 32;
  localparam int NUM_W    = 48;
  localparam int PROD_W   = 80;
  localparam int CNT_W    = $clog2(NUM_W);

  localparam logic [VAL_W-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [VAL_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] MIN_VAL = 32'h8000_0000;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    REG_KEY_COUNT    = 2'd0,
    REG_STEP_MODE    = 2'd1,
    REG_DEFAULT_KIND = 2'd2
  } ksv_reg_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SCAN, BK_RD0, BK_RD1, BK_RD2, BK_DIV, BK_MSET, BK_MUL, BK_FIN
  } ksv_state_t;

  // Classified command as held in the queue
  typedef struct packed {
    logic              is_sample;
    logic [5:0]        slot;
    logic [VAL_W-1:0]  tm;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } ksv_cmd_t;

  typedef struct packed {
    logic [KC_W-1:0] key_count;
    logic            step_mode;
    logic            default_kind;
  } ksv_cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
    logic [5:0]       seg;
    logic             sat;
  } ksv_res_t;

endpackage
`default_nettype wire

// File: hdl/ksv_if.sv
`default_nettype none
interface ksv_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  key_slot;
  logic [31:0] key_time;
  logic [31:0] key_x;
  logic [31:0] key_y;
  logic [31:0] key_z;
  logic [31:0] sample_time;

  modport source (output valid, command, key_slot, key_time, key_x, key_y, key_z,
                  sample_time, input ready);
  modport sink   (input valid, command, key_slot, key_time, key_x, key_y, key_z,
                  sample_time, output ready);
endinterface

interface ksv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [5:0]  segment;
  logic        saturated;

  modport source (output valid, out_x, out_y, out_z, segment, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, segment, saturated, output ready);
endinterface
`default_nettype wire

// File: hdl/ksv_front.sv
`default_nettype none
module ksv_front
  import ksv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  ksv_in_if.sink        in_if,
  output ksv_cmd_t      q_cmd,
  output logic          q_vld,
  input  wire logic     q_pop
);

  ksv_cmd_t    q_mem [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  ksv_cmd_t    cls;
  logic        push;

  // Classify: a sample carries its sample time in the shared time slot
  always_comb begin
    cls.is_sample = (in_if.command == CMD_SAMPLE);
    cls.slot      = in_if.key_slot;
    cls.tm        = (in_if.command == CMD_SAMPLE) ? in_if.sample_time : in_if.key_time;
    cls.x         = in_if.key_x;
    cls.y         = in_if.key_y;
    cls.z         = in_if.key_z;
  end

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign q_vld       = (cnt_r != 2'd0);
  assign q_cmd       = q_mem[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

// File: hdl/ksv_back.sv
`default_nettype none
module ksv_back
  import ksv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ksv_cfg_t cfg,
  input  wire ksv_cmd_t q_cmd,
  input  wire logic     q_vld,
  output logic          q_pop,
  ksv_out_if.source     out_if
);

  // Key table
  logic [VAL_W-1:0]   times_mem [MAX_KEYS];
  logic [3*VAL_W-1:0] vals_mem  [MAX_KEYS];
  logic [VAL_W-1:0]   rd_time_r;
  logic [3*VAL_W-1:0] rd_val_r;
  logic [KEY_AW-1:0]  rd_addr;
  logic               wr_en;

  ksv_state_t state_r, state_nxt;

  logic [N_W-1:0]    n_r, iss_r, chk_k_r, idx_r, idx_p1, n_sel;
  logic              chk_vld_r;
  logic [VAL_W-1:0]  t_r, prev_r, time0_r, time1_r, t0_r, t1_r;
  logic              def_r, hold_r, negf_r;
  logic [VAL_W-1:0]  v0_r [3];
  logic [VAL_W-1:0]  v1_r [3];
  logic [NUM_W-1:0]  num_r, mplr_r;
  logic [VAL_W-1:0]  den_r, rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] mcand_r [3];
  logic [PROD_W-1:0] acc_r [3];
  logic              neg_r [3];

  logic              hit, last;
  logic [VAL_W:0]    dk, dt, div_sh;
  logic              div_q;
  logic              ovld_r;
  ksv_res_t          ores_r, res;
  logic              out_free;

  assign idx_p1   = idx_r + N_W'(1);
  assign n_sel    = (N_W'(cfg.key_count) > N_W'(MAX_KEYS)) ? N_W'(MAX_KEYS)
                                                           : N_W'(cfg.key_count);
  assign out_free = !ovld_r || out_if.ready;

  // Scan compare on the time just read
  assign hit  = chk_vld_r && (chk_k_r != '0) && (t_r >= prev_r) && (t_r < rd_time_r);
  assign last = chk_vld_r && (chk_k_r == n_r - N_W'(1));

  // Segment deltas
  assign dk = {1'b0, t1_r} - {1'b0, t0_r};
  assign dt = {1'b0, t_r} - {1'b0, t0_r};

  // One restoring division step
  assign div_sh = {rem_r, num_r[NUM_W-1]};
  assign div_q  = (div_sh >= {1'b0, den_r});

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = idx_r[KEY_AW-1:0];
    case (state_r)
      BK_IDLE: begin
        if (q_vld) begin
          q_pop = 1'b1;
          if (!q_cmd.is_sample) begin
            wr_en = (int'(q_cmd.slot) < MAX_KEYS);
          end else if (n_sel == '0) begin
            state_nxt = BK_FIN;
          end else begin
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        rd_addr = iss_r[KEY_AW-1:0];
        if (hit || last) begin
          state_nxt = BK_RD0;
        end
      end
      BK_RD0: state_nxt = BK_RD1;
      BK_RD1: begin
        rd_addr   = idx_p1[KEY_AW-1:0];
        state_nxt = BK_RD2;
      end
      BK_RD2: begin
        if (cfg.step_mode || (idx_p1 >= n_r) || (dk == '0)) begin
          state_nxt = BK_FIN;
        end else begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = BK_MSET;
        end
      end
      BK_MSET: state_nxt = BK_MUL;
      BK_MUL: begin
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Table write and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      times_mem[KEY_AW'(q_cmd.slot)] <= q_cmd.tm;
      vals_mem[KEY_AW'(q_cmd.slot)]  <= {q_cmd.x, q_cmd.y, q_cmd.z};
    end
    rd_time_r <= times_mem[rd_addr];
    rd_val_r  <= vals_mem[rd_addr];
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (state_r == BK_SCAN && !(hit || last) && iss_r < n_r) begin
      chk_vld_r <= 1'b1;
    end else begin
      chk_vld_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        t_r   <= q_cmd.tm;
        n_r   <= n_sel;
        iss_r <= '0;
        idx_r <= '0;
        def_r <= (n_sel == '0);
        hold_r <= 1'b1;
      end
      BK_SCAN: begin
        iss_r   <= iss_r + N_W'(1);
        chk_k_r <= iss_r;
        if (chk_vld_r) begin
          prev_r <= rd_time_r;
          if (chk_k_r == '0) begin
            time0_r <= rd_time_r;
          end
          if (chk_k_r == N_W'(1)) begin
            time1_r <= rd_time_r;
          end
        end
        if (hit) begin
          idx_r <= chk_k_r - N_W'(1);
          t0_r  <= prev_r;
          t1_r  <= rd_time_r;
        end else if (last) begin
          // Past the last key holds it; before the first key extrapolates segment 0
          idx_r <= (t_r >= rd_time_r) ? chk_k_r : '0;
          t0_r  <= (chk_k_r == '0) ? rd_time_r : time0_r;
          t1_r  <= (chk_k_r == N_W'(1)) ? rd_time_r : time1_r;
        end
      end
      BK_RD1: begin
        v0_r[0] <= rd_val_r[3*VAL_W-1:2*VAL_W];
        v0_r[1] <= rd_val_r[2*VAL_W-1:VAL_W];
        v0_r[2] <= rd_val_r[VAL_W-1:0];
      end
      BK_RD2: begin
        v1_r[0] <= rd_val_r[3*VAL_W-1:2*VAL_W];
        v1_r[1] <= rd_val_r[2*VAL_W-1:VAL_W];
        v1_r[2] <= rd_val_r[VAL_W-1:0];
        hold_r  <= cfg.step_mode || (idx_p1 >= n_r) || (dk == '0);
        num_r   <= {(dt[VAL_W] ? VAL_W'(-dt) : dt[VAL_W-1:0]), 16'h0000};
        den_r   <= dk[VAL_W] ? VAL_W'(-dk) : dk[VAL_W-1:0];
        rem_r   <= '0;
        cnt_r   <= '0;
        negf_r  <= dt[VAL_W] ^ dk[VAL_W];
      end
      BK_DIV: begin
        rem_r <= div_q ? VAL_W'(div_sh - {1'b0, den_r}) : div_sh[VAL_W-1:0];
        num_r <= {num_r[NUM_W-2:0], div_q};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      BK_MSET: begin
        mplr_r <= num_r;
        cnt_r  <= '0;
        for (int k = 0; k < 3; k++) begin
          logic [VAL_W:0] dv;
          dv = {v1_r[k][VAL_W-1], v1_r[k]} - {v0_r[k][VAL_W-1], v0_r[k]};
          mcand_r[k] <= PROD_W'(dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0]);
          acc_r[k]   <= '0;
          neg_r[k]   <= dv[VAL_W] ^ negf_r;
        end
      end
      BK_MUL: begin
        mplr_r <= mplr_r >> 1;
        cnt_r  <= cnt_r + CNT_W'(1);
        for (int k = 0; k < 3; k++) begin
          if (mplr_r[0]) begin
            acc_r[k] <= acc_r[k] + mcand_r[k];
          end
          mcand_r[k] <= mcand_r[k] << 1;
        end
      end
      default: ;
    endcase
  end

  // Result forming: default, held key, or offset plus scaled delta with clipping
  always_comb begin
    logic [VAL_W-1:0] r [3];
    logic             s [3];
    logic [VAL_W+2:0] term, sum;
    for (int k = 0; k < 3; k++) begin
      term = {2'b00, acc_r[k][48:16]};
      if (neg_r[k]) begin
        term = -term;
      end
      sum  = {{3{v0_r[k][VAL_W-1]}}, v0_r[k]} + term;
      s[k] = 1'b0;
      if (def_r) begin
        r[k] = cfg.default_kind ? ONE_Q : '0;
      end else if (hold_r) begin
        r[k] = v0_r[k];
      end else if (|acc_r[k][PROD_W-1:49]) begin
        s[k] = 1'b1;
        r[k] = neg_r[k] ? MIN_VAL : MAX_VAL;
      end else if (sum[VAL_W+2:VAL_W-1] != {4{sum[VAL_W+2]}}) begin
        s[k] = 1'b1;
        r[k] = sum[VAL_W+2] ? MIN_VAL : MAX_VAL;
      end else begin
        r[k] = sum[VAL_W-1:0];
      end
    end
    res.x   = r[0];
    res.y   = r[1];
    res.z   = r[2];
    res.seg = 6'(idx_r);
    res.sat = s[0] | s[1] | s[2];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (state_r == BK_FIN && out_free) begin
      ovld_r <= 1'b1;
    end else if (out_if.ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_FIN && out_free) begin
      ores_r <= res;
    end
  end

  assign out_if.valid     = ovld_r;
  assign out_if.out_x     = ores_r.x;
  assign out_if.out_y     = ores_r.y;
  assign out_if.out_z     = ores_r.z;
  assign out_if.segment   = ores_r.seg;
  assign out_if.saturated = ores_r.sat;

endmodule
`default_nettype wire

// File: hdl/keyframe_vector_sampler.sv
// Channel  Dir  Transfer when         Carries
// in_if    in   valid && ready        command, key_slot, key_time, key_x/y/z, sample_time
// out_if   out  valid && ready        out_x/y/z, segment, saturated (samples only)
// cfg_*    in   cfg_we high           cfg_index, cfg_data (key_count, step_mode, default_kind)
//
// A load is one table write in the back end. A sample that holds a key scans the
// n keys through the single table read port; one that interpolates then runs a
// bit-serial division, a set-up step and a bit-serial multiply.
// A two-entry queue lets input transfers continue while the back end works; the
// output register frees the back end while a result waits. Reset is synchronous,
// clears control state and the configuration registers; the key table holds no reset value.
`default_nettype none
module keyframe_vector_sampler
  import ksv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  ksv_in_if.sink          in_if,
  ksv_out_if.source       out_if,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  ksv_cfg_t cfg_r;
  ksv_cmd_t q_cmd;
  logic     q_vld, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (ksv_reg_t'(cfg_index))
        REG_KEY_COUNT:    cfg_r.key_count    <= cfg_data;
        REG_STEP_MODE:    cfg_r.step_mode    <= cfg_data[0];
        REG_DEFAULT_KIND: cfg_r.default_kind <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ksv_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .q_cmd (q_cmd),
    .q_vld (q_vld),
    .q_pop (q_pop)
  );

  ksv_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_cmd  (q_cmd),
    .q_vld  (q_vld),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

// File: hdl/ksv_checker.sv
`default_nettype none
module ksv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_x,
  input wire logic [31:0] out_y,
  input wire logic [31:0] out_z,
  input wire logic        saturated
);

  // A result that waits is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result changed while stalled");

  // Nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Clipping leaves a component at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      out_x == 32'h7FFF_FFFF || out_x == 32'h8000_0000 ||
      out_y == 32'h7FFF_FFFF || out_y == 32'h8000_0000 ||
      out_z == 32'h7FFF_FFFF || out_z == 32'h8000_0000)
    else $error("saturated flag without a clipped component");

endmodule

bind keyframe_vector_sampler ksv_checker u_ksv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_x     (out_if.out_x),
  .out_y     (out_if.out_y),
  .out_z     (out_if.out_z),
  .saturated (out_if.saturated)
);
`default_nettype wire

// File: verif/ksv_checker.sv
`timescale 1ns / 1ps
// Watches the channels and the register port, keeps its own copy of the key
// table and settings, and checks each sample result against its prediction.
module ksv_scoreboard
  import ksv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  ksv_in_if               in_if,
  ksv_out_if              out_if,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  output int              fail_count,
  output int              pending,
  output int              results_seen,
  output int              clipped_seen
);

  logic [31:0] key_times  [MAX_KEYS];
  logic [31:0] key_values [MAX_KEYS][3];
  ksv_cfg_t    settings;
  ksv_res_t    expected_samples [$];

  // One component along a segment, clipped to 32-bit signed
  function automatic longint lerp_axis(longint v0, longint v1, longint f, ref bit clipped);
    longint dv;
    longint unsigned mdv, mf, term;
    bit neg;
    longint r;
    dv  = v1 - v0;
    mdv = (dv < 0) ? longint'(-dv) : longint'(dv);
    mf  = (f < 0) ? longint'(-f) : longint'(f);
    neg = (dv < 0) != (f < 0);
    if (mdv == 0 || mf == 0) return v0;
    if (mf > (((64'd1 << 49) - 1) / mdv)) begin
      clipped = 1'b1;
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    term = (mdv * mf) >> 16;
    r = neg ? v0 - longint'(term) : v0 + longint'(term);
    if (r > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (r < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return r;
  endfunction

  // Value of the table at time t under the current settings
  function automatic ksv_res_t predict_sample(logic [31:0] t);
    ksv_res_t r;
    int n, idx, k;
    bit found, clipped;
    longint t0, t1, dk, f, tl, v;
    r = '0;
    n = (settings.key_count > MAX_KEYS) ? MAX_KEYS : int'(settings.key_count);
    idx = 0;
    found = 0;
    clipped = 0;
    if (n == 0) begin
      r.x = settings.default_kind ? ONE_Q : '0;
      r.y = r.x;
      r.z = r.x;
    end else begin
      for (k = 0; k + 1 < n && !found; k++) begin
        if (t >= key_times[k] && t < key_times[k+1]) begin
          idx = k;
          found = 1;
        end
      end
      if (!found && t >= key_times[n-1]) idx = n - 1;
      if (n == 1) idx = 0;
      t0 = key_times[idx];
      t1 = (idx + 1 < n) ? key_times[idx+1] : 0;
      dk = t1 - t0;
      if (idx + 1 >= n || settings.step_mode || dk == 0) begin
        r.x = key_values[idx][0];
        r.y = key_values[idx][1];
        r.z = key_values[idx][2];
      end else begin
        tl = t;
        f = ((tl - t0) * 65536) / dk;
        v = lerp_axis($signed(key_values[idx][0]), $signed(key_values[idx+1][0]), f, clipped);
        r.x = v[31:0];
        v = lerp_axis($signed(key_values[idx][1]), $signed(key_values[idx+1][1]), f, clipped);
        r.y = v[31:0];
        v = lerp_axis($signed(key_values[idx][2]), $signed(key_values[idx+1][2]), f, clipped);
        r.z = v[31:0];
      end
    end
    r.seg = idx[5:0];
    r.sat = clipped;
    return r;
  endfunction

  always @(posedge clk) begin
    ksv_res_t got, want;
    if (!rst_n) begin
      settings <= '0;
      expected_samples.delete();
      fail_count <= 0;
      pending <= 0;
      results_seen <= 0;
      clipped_seen <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_COUNT:    settings.key_count    <= cfg_data;
          REG_STEP_MODE:    settings.step_mode    <= cfg_data[0];
          REG_DEFAULT_KIND: settings.default_kind <= cfg_data[0];
          default: ;
        endcase
      end
      // result transfer: compare with the oldest prediction
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_x, out_if.out_y, out_if.out_z, out_if.segment, out_if.saturated};
        results_seen <= results_seen + 1;
        if (got.sat) clipped_seen <= clipped_seen + 1;
        if (expected_samples.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with none expected: x=%h y=%h z=%h seg=%0d sat=%b",
                     $time, got.x, got.y, got.z, got.seg, got.sat);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"%0t: mismatch exp x=%h y=%h z=%h seg=%0d sat=%b",
                        " / got x=%h y=%h z=%h seg=%0d sat=%b"},
                       $time, want.x, want.y, want.z, want.seg, want.sat,
                       got.x, got.y, got.z, got.seg, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      // input transfer: loads update the table, samples queue a prediction
      if (in_if.valid && in_if.ready) begin
        if (in_if.command == CMD_LOAD) begin
          key_times[in_if.key_slot]     <= in_if.key_time;
          key_values[in_if.key_slot][0] <= in_if.key_x;
          key_values[in_if.key_slot][1] <= in_if.key_y;
          key_values[in_if.key_slot][2] <= in_if.key_z;
        end else begin
          expected_samples = {expected_samples, predict_sample(in_if.sample_time)};
        end
      end
      pending <= expected_samples.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import ksv_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1150;
  localparam int SETTLE_CYCLES = 250;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int         fail_count, pending, results_seen, clipped_seen;
  int         items_sent, loads_sent, samples_sent;
  logic [31:0] slot_time [MAX_KEYS];
  int         cur_keys;

  ksv_in_if  in_if ();
  ksv_out_if out_if ();

  keyframe_vector_sampler u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ksv_scoreboard u_chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .clipped_seen(clipped_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side back-pressure: stretches of full, patchy, sparse and stalled
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 9);
        left = (mode == 9) ? $urandom_range(30, 80) : $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0, 1, 2, 3: out_if.ready <= 1'b1;
        4, 5, 6:    out_if.ready <= ($urandom_range(0, 9) < 7);
        9:          out_if.ready <= 1'b0;
        default:    out_if.ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // Mostly short gaps between transfers, a few long ones
  task automatic pause_sender();
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 70);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(logic cmd, logic [5:0] slot, logic [31:0] kt,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] st);
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.key_slot    <= slot;
    in_if.key_time    <= kt;
    in_if.key_x       <= x;
    in_if.key_y       <= y;
    in_if.key_z       <= z;
    in_if.sample_time <= st;
    // ready as seen at the edge itself, before the queue count moves
    @(posedge clk iff in_if.ready);
    items_sent++;
    pause_sender();
  endtask

  task automatic load_key(logic [5:0] slot, logic [31:0] kt,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
    slot_time[slot] = kt;
    loads_sent++;
    send_item(CMD_LOAD, slot, kt, x, y, z, $urandom);
  endtask

  // Unused key fields carry junk on a sample
  task automatic sample_at(logic [31:0] t);
    samples_sent++;
    send_item(CMD_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, t);
  endtask

  // Registers change only once the block has drained
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_KEY_COUNT) cur_keys = (val > MAX_KEYS) ? MAX_KEYS : int'(val);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Rewrite all slots: dense, sparse, tiny-gap sorted, or scrambled times
  task automatic fill_table();
    int style;
    logic [31:0] t;
    style = $urandom_range(0, 3);
    t = (style == 2) ? $urandom : $urandom_range(0, 32'h0010_0000);
    for (int s = 0; s < MAX_KEYS; s++) begin
      case (style)
        0:       t = t + $urandom_range(0, 32'h0004_0000);
        1:       t = t + $urandom_range(0, 32'h0300_0000);
        2:       t = $urandom;
        default: t = t + $urandom_range(0, 3);
      endcase
      load_key(6'(s), t, pick_value(), pick_value(), pick_value());
    end
  endtask

  function automatic logic [31:0] pick_time();
    int r, k;
    r = $urandom_range(0, 99);
    k = (cur_keys > 0) ? $urandom_range(0, cur_keys - 1) : 0;
    if (r < 60) return slot_time[k] + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    if (r < 75) return slot_time[k];
    if (r < 85) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  initial begin
    int kc;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_COUNT;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.key_slot = '0;
    in_if.key_time = '0;
    in_if.key_x = '0;
    in_if.key_y = '0;
    in_if.key_z = '0;
    in_if.sample_time = '0;
    items_sent = 0;
    loads_sent = 0;
    samples_sent = 0;
    cur_keys = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, zeros then ones
    sample_at(32'h0);
    sample_at(32'hFFFF_FFFF);
    settle();
    write_reg(REG_DEFAULT_KIND, 7'd1);
    write_reg(REG_UNUSED, 7'h7F);
    sample_at(32'h1234_5678);

    // single key returned whatever the time
    load_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    settle();
    write_reg(REG_KEY_COUNT, 7'd1);
    sample_at(32'h0);
    sample_at(32'h0001_0000);
    sample_at(32'hFFFF_FFFF);

    // extremes, equal times and out-of-order times
    load_key(6'd1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    load_key(6'd2, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF);
    load_key(6'd3, 32'h0000_0010, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    load_key(6'd63, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3);
    settle();
    write_reg(REG_KEY_COUNT, 7'd4);
    write_reg(REG_DEFAULT_KIND, 7'd0);
    sample_at(32'h0);
    sample_at(32'h0000_8000);
    sample_at(32'h0001_8000);
    sample_at(32'h0002_0000);
    sample_at(32'hFFFF_FFFF);
    settle();
    write_reg(REG_STEP_MODE, 7'd1);
    sample_at(32'h0);
    sample_at(32'h0001_8000);

    // random phases, each under its own settings
    fill_table();
    while (items_sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 7))
        0:       kc = 0;
        1:       kc = 1;
        2:       kc = 2;
        3:       kc = MAX_KEYS;
        4:       kc = $urandom_range(MAX_KEYS + 1, 127);
        default: kc = $urandom_range(2, MAX_KEYS);
      endcase
      write_reg(REG_KEY_COUNT, kc[6:0]);
      write_reg(REG_STEP_MODE, 7'($urandom_range(0, 3) == 0));
      write_reg(REG_DEFAULT_KIND, 7'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) fill_table();
      repeat (60) begin
        if ($urandom_range(0, 99) < 15)
          load_key(6'($urandom), pick_time(), pick_value(), pick_value(), pick_value());
        else
          sample_at(pick_time());
      end
    end

    settle();
    $display("Run covered %0d transfers in: %0d key loads, %0d samples.",
             items_sent, loads_sent, samples_sent);
    $display("Results checked: %0d, of which %0d clipped.", results_seen, clipped_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
